>>> rtl/core/mlsd_pkg.sv
// constants and types shared by the magic/length stream deframer files
package mlsd_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned LenW    = 16;
   localparam int unsigned StatusW = 2;
   localparam int unsigned PhaseW  = 3;

   // frame header magic bytes
   localparam logic [ByteW-1:0] MAGIC_FIRST  = 8'h94;
   localparam logic [ByteW-1:0] MAGIC_SECOND = 8'hC3;

   // result status codes
   localparam logic [StatusW-1:0] ST_PAYLOAD = 2'd0;
   localparam logic [StatusW-1:0] ST_DROPPED = 2'd1;
   localparam logic [StatusW-1:0] ST_EMPTY   = 2'd2;

   // parser phase codes
   localparam logic [PhaseW-1:0] PH_HUNT0 = 3'd0;
   localparam logic [PhaseW-1:0] PH_HUNT1 = 3'd1;
   localparam logic [PhaseW-1:0] PH_LENHI = 3'd2;
   localparam logic [PhaseW-1:0] PH_LENLO = 3'd3;
   localparam logic [PhaseW-1:0] PH_DATA  = 3'd4;

   localparam logic [LenW-1:0] MAX_PAYLOAD_RESET = 16'd512;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [ByteW-1:0]   data_byte;
      logic [LenW-1:0]    frame_length;
      logic               last;
   } rsp_word_type;

endpackage

>>> rtl/core/mlsd_if.sv
// valid/ready channel interfaces for the deframer input and result streams
interface mlsd_req_if import mlsd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface mlsd_rsp_if import mlsd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [StatusW-1:0] status;
   logic [ByteW-1:0]   data_byte;
   logic [LenW-1:0]    frame_length;
   logic               last;

   modport source (output valid, output status, output data_byte, output frame_length,
                   output last, input ready);
   modport sink   (input valid, input status, input data_byte, input frame_length,
                   input last, output ready);
endinterface

>>> rtl/core/magic_length_stream_deframer.sv
// magic-word, length-prefixed byte stream deframer (top level)
//
//   channel   dir  handshake        payload
//   req_bus   in   valid/ready      byte_in[7:0]
//   rsp_bus   out  valid/ready      status[1:0] data_byte[7:0] frame_length[15:0] last
//   csr_*     in   csr_we           csr_wdata[15:0] -> max_payload
//
// while req_bus.ready is high one byte is taken per cycle; parser state and result
// register update at the accepting edge; a byte's result is on rsp_bus next cycle
// reset (synchronous, active high) puts the parser in hunt and max_payload at 512
// req_bus.ready stays high while the result register is empty or being drained,
// so a stalled sink holds at most one word and stops the input only then
module magic_length_stream_deframer import mlsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mlsd_req_if.sink   req_bus,
   mlsd_rsp_if.source rsp_bus,
   input  logic       csr_we,
   input  logic [LenW-1:0] csr_wdata
);

   // parser state
   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [ByteW-1:0]  length_high_ff, length_high_in;
   logic [LenW-1:0]   frame_len_ff, frame_len_in;
   logic [LenW-1:0]   remaining_ff, remaining_in;
   logic [LenW-1:0]   max_payload_ff;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         accept;
   logic         emit;
   logic [LenW-1:0] hdr_len;
   logic         is_last;

   // a word may enter whenever the output slot is free or leaves this cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign hdr_len = {length_high_ff, req_bus.byte_in};
   assign is_last = (remaining_ff <= LenW'(1));

   always_comb begin
      phase_in       = phase_ff;
      length_high_in = length_high_ff;
      frame_len_in   = frame_len_ff;
      remaining_in   = remaining_ff;
      emit           = 1'b0;
      rsp_word_in    = rsp_word_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT1: begin
               // a repeated first magic byte keeps us waiting for the second
               if (req_bus.byte_in == MAGIC_SECOND) begin
                  phase_in = PH_LENHI;
               end else if (req_bus.byte_in == MAGIC_FIRST) begin
                  phase_in = PH_HUNT1;
               end else begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_LENHI: begin
               length_high_in = req_bus.byte_in;
               phase_in       = PH_LENLO;
            end
            PH_LENLO: begin
               frame_len_in = hdr_len;
               if (hdr_len > max_payload_ff) begin
                  // oversized: report and go back to hunting in the payload bytes
                  phase_in     = PH_HUNT0;
                  remaining_in = '0;
                  emit         = 1'b1;
                  rsp_word_in  = '{status: ST_DROPPED, data_byte: '0,
                                   frame_length: hdr_len, last: 1'b1};
               end else if (hdr_len == '0) begin
                  phase_in     = PH_HUNT0;
                  remaining_in = '0;
                  emit         = 1'b1;
                  rsp_word_in  = '{status: ST_EMPTY, data_byte: '0,
                                   frame_length: '0, last: 1'b1};
               end else begin
                  remaining_in = hdr_len;
                  phase_in     = PH_DATA;
               end
            end
            PH_DATA: begin
               emit        = 1'b1;
               rsp_word_in = '{status: ST_PAYLOAD, data_byte: req_bus.byte_in,
                               frame_length: frame_len_ff, last: is_last};
               if (is_last) begin
                  remaining_in = '0;
                  phase_in     = PH_HUNT0;
               end else begin
                  remaining_in = remaining_ff - LenW'(1);
               end
            end
            default: begin
               // hunting, and the unreachable codes behave the same
               phase_in = (req_bus.byte_in == MAGIC_FIRST) ? PH_HUNT1 : PH_HUNT0;
            end
         endcase
      end
   end

   // output slot fills on a result, empties when the sink takes it
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT0;
         length_high_ff <= '0;
         frame_len_ff   <= '0;
         remaining_ff   <= '0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         length_high_ff <= length_high_in;
         frame_len_ff   <= frame_len_in;
         remaining_ff   <= remaining_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            max_payload_ff <= csr_wdata;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_word_ff.status;
   assign rsp_bus.data_byte    = rsp_word_ff.data_byte;
   assign rsp_bus.frame_length = rsp_word_ff.frame_length;
   assign rsp_bus.last         = rsp_word_ff.last;

endmodule
